// File: rtl/core/signed_int_to_decimal_ascii_core_macros.svh
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_macros
// Assertion macros shared by the conversion core.
// ----------------------------------------------------------------------------
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define SITDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication between an antecedent and a consequent.
`define SITDA_ASSERT_IMP(lbl, ante, cons, msg) \
  `SITDA_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: rtl/core/sitda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_pkg
// Types and constants shared by the signed integer to decimal text core.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int unsigned MagW      = 32;
  localparam int unsigned NumDigits = 10;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned IdxW      = $clog2(NumDigits);
  localparam int unsigned CntW      = $clog2(MagW);
  localparam int unsigned CharW     = 8;

  localparam logic [CharW-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CharW-1:0] ASCII_MINUS = 8'd45;

  typedef logic [MagW-1:0]                  mag_t;
  typedef logic [NumDigits-1:0][DigitW-1:0] bcd_t;
  typedef logic [IdxW-1:0]                  idx_t;
  typedef logic [CharW-1:0]                 char_t;

  // Top-level sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } top_state_e;

  // Character emitter states.
  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SIGN,
    EM_DIGIT
  } emit_state_e;

  // Everything the emitter needs to start on one number.
  typedef struct packed {
    logic neg;
    bcd_t bcd;
    idx_t lead;
  } emit_load_t;

  // Position of the most significant non-zero digit; zero gives the units digit.
  function automatic idx_t lead_digit(input bcd_t bcd);
    idx_t lead;
    lead = '0;
    for (int unsigned i = 0; i < NumDigits; i++) begin
      if (bcd[i] != '0) begin
        lead = idx_t'(i);
      end
    end
    return lead;
  endfunction

endpackage

// File: rtl/core/sitda_dabble.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_dabble
// Iterative binary to BCD converter: one shift-and-correct step per cycle.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_core_macros.svh"

module sitda_dabble (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  sitda_pkg::mag_t mag_i,
  output logic            done_o,
  output sitda_pkg::bcd_t bcd_o
);
  import sitda_pkg::*;

  localparam logic [CntW-1:0] LastCnt = CntW'(MagW - 1);

  mag_t                        bin_q, bin_d;
  bcd_t                        bcd_q, bcd_d;
  bcd_t                        corr;
  logic [NumDigits*DigitW-1:0] corr_flat;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        busy_q, busy_d;
  logic                        done_q, done_d;

  // Each digit of five or more is raised by three so that the following
  // shift carries correctly into the next decimal place.
  always_comb begin
    for (int unsigned i = 0; i < NumDigits; i++) begin
      corr[i] = (bcd_q[i] >= DigitW'(5)) ? bcd_q[i] + DigitW'(3) : bcd_q[i];
    end
  end

  assign corr_flat = corr;

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = mag_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bin_d = {bin_q[MagW-2:0], 1'b0};
      bcd_d = {corr_flat[NumDigits*DigitW-2:0], bin_q[MagW-1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

  `SITDA_ASSERT_IMP(a_done_after_busy, done_q, $past(busy_q) && !busy_q, "done without a conversion")
  `SITDA_ASSERT_IMP(a_start_when_idle, start_i, !busy_q, "conversion restarted while busy")

endmodule

// File: rtl/core/sitda_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sitda_emit
// Character sequencer: sends the sign and the digits through an output register.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_core_macros.svh"

module sitda_emit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  sitda_pkg::emit_load_t load_data_i,
  output logic                  busy_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sitda_pkg::char_t      character_o,
  output logic                  last_char_o
);
  import sitda_pkg::*;

  emit_state_e state_q, state_d;
  bcd_t        bcd_q, bcd_d;
  idx_t        idx_q, idx_d;
  logic        valid_q, valid_d;
  char_t       char_q, char_d;
  logic        last_q, last_d;
  logic        advance;

  // The output register can take a new character when empty or being drained.
  assign advance = !valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    bcd_d   = bcd_q;
    idx_d   = idx_q;
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    if (advance) begin
      valid_d = 1'b0;
    end
    unique case (state_q)
      EM_IDLE: begin
        if (load_i) begin
          bcd_d   = load_data_i.bcd;
          idx_d   = load_data_i.lead;
          state_d = load_data_i.neg ? EM_SIGN : EM_DIGIT;
        end
      end
      EM_SIGN: begin
        if (advance) begin
          valid_d = 1'b1;
          char_d  = ASCII_MINUS;
          last_d  = 1'b0;
          state_d = EM_DIGIT;
        end
      end
      EM_DIGIT: begin
        if (advance) begin
          valid_d = 1'b1;
          char_d  = ASCII_ZERO + {{(CharW-DigitW){1'b0}}, bcd_q[idx_q]};
          last_d  = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = EM_IDLE;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: state_d = EM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EM_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign busy_o      = (state_q != EM_IDLE);
  assign out_valid_o = valid_q;
  assign character_o = char_q;
  assign last_char_o = last_q;

  `SITDA_ASSERT_IMP(a_load_when_idle, load_i, state_q == EM_IDLE, "emitter loaded while busy")

endmodule

// File: rtl/core/signed_int_to_decimal_ascii_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a signed 32-bit integer to its decimal ASCII text, one character
// per output transaction, most significant first, sign in front.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake               Payload
//   in       sink       in_valid_i / in_stall_o   number_i
//   out      source     out_valid_o / out_stall_i character_o, last_char_o
//
// A number passes through the shift-and-add-3 converter and is then loaded into
// the character sequencer, which sends one character per cycle (1 to 11 in all)
// while the output is not stalled. A new number is accepted only after the last
// character has entered the output register and the top sequencer has gone
// back to idle. Output stalls hold the character register and delay the
// sequence.
// Reset clears all control state; no clearing pass is needed.
`include "signed_int_to_decimal_ascii_core_macros.svh"

module signed_int_to_decimal_ascii_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  number_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          character_o,
  output logic                last_char_o
);
  import sitda_pkg::*;

  top_state_e state_q, state_d;
  logic       in_accept;
  mag_t       num_raw;
  mag_t       mag;
  logic       neg_q;
  logic       dab_done;
  bcd_t       dab_bcd;
  logic       emit_load;
  emit_load_t load_data;
  logic       emit_busy;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // The magnitude is formed modulo 2^32, so the most negative value maps to
  // its own unsigned bit pattern without overflow.
  assign num_raw = mag_t'(number_i);
  assign mag     = num_raw[MagW-1] ? (~num_raw + 1'b1) : num_raw;

  always_comb begin
    state_d   = state_q;
    emit_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        if (dab_done) begin
          emit_load = 1'b1;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!emit_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      neg_q <= num_raw[MagW-1];
    end
  end

  assign load_data.neg  = neg_q;
  assign load_data.bcd  = dab_bcd;
  assign load_data.lead = lead_digit(dab_bcd);

  sitda_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .mag_i   (mag),
    .done_o  (dab_done),
    .bcd_o   (dab_bcd)
  );

  sitda_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit_load),
    .load_data_i (load_data),
    .busy_o      (emit_busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_char_o (last_char_o)
  );

  `SITDA_ASSERT_IMP(a_done_in_conv, dab_done, state_q == ST_CONV, "conversion finished outside CONV")
  `SITDA_ASSERT(a_accept_to_conv, in_accept |=> state_q == ST_CONV, "accepted number not converted")

endmodule

// File: sim/signed_int_to_decimal_ascii_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core_tb
// Drives signed 32-bit numbers into the core and checks every character it
// returns against a predicted decimal text: sign, digit order and end marker.
// The sender works in bursts with gaps and the receiver stalls in changing
// patterns.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core_tb;
  import sitda_pkg::*;

  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned RandomItems = 500;
  localparam int unsigned ReportLimit = 10;

  typedef struct {
    char_t code;
    logic  is_last;
  } text_char_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic signed [31:0] number_i    = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [7:0]         character_o;
  logic               last_char_o;

  text_char_t  pending_chars[$];
  text_char_t  next_char;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned burst_left     = 0;
  int unsigned stall_mode     = 0;
  int unsigned stall_phase    = 0;

  signed_int_to_decimal_ascii_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .number_i    (number_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_char_o (last_char_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Works out the decimal text of one number and queues its characters.
  function automatic void predict_decimal_text(input logic signed [31:0] value);
    logic [31:0] magnitude;
    logic [3:0]  digits[NumDigits];
    int          count;
    text_char_t  entry;
    count = 0;
    // Negation in unsigned arithmetic keeps the most negative value exact.
    magnitude = value[31] ? (32'd0 - value) : value;
    do begin
      digits[count] = 4'(magnitude % 10);
      magnitude     = magnitude / 10;
      count++;
    end while (magnitude != 0 && count < NumDigits);
    if (value[31]) begin
      entry.code    = ASCII_MINUS;
      entry.is_last = 1'b0;
      pending_chars.insert(pending_chars.size(), entry);
    end
    for (int i = count - 1; i >= 0; i--) begin
      entry.code    = ASCII_ZERO + char_t'(digits[i]);
      entry.is_last = (i == 0);
      pending_chars.insert(pending_chars.size(), entry);
    end
  endfunction

  // Sends one number; between bursts the valid line may drop for a random gap.
  task automatic send_number(input logic signed [31:0] value);
    int unsigned gap_len;
    if (burst_left == 0) begin
      gap_len    = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
      burst_left = $urandom_range(20, 1);
      if (gap_len != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    number_i   <= value;
    do @(posedge clk_i); while (in_stall_o);
    predict_decimal_text(value);
  endtask

  task automatic test_zero_and_units();
    send_number(32'sd0);
    send_number(32'sd1);
    send_number(-32'sd1);
    send_number(32'sd9);
    send_number(-32'sd9);
  endtask

  task automatic test_extremes();
    send_number(32'sh7FFF_FFFF);
    send_number(32'sh8000_0000);
    send_number(32'sh8000_0001);
    send_number(32'sd1000000000);
    send_number(-32'sd1000000000);
  endtask

  task automatic test_length_boundaries();
    send_number(32'sd10);
    send_number(-32'sd10);
    send_number(32'sd99);
    send_number(32'sd100);
    send_number(-32'sd999);
    send_number(32'sd9999999);
    send_number(32'sd10000000);
    send_number(-32'sd999999999);
    send_number(32'sd1234567890);
    send_number(-32'sd1234567890);
  endtask

  // Mix of numbers shaped by text length, raw bit patterns and small values.
  task automatic test_random_numbers();
    int unsigned       pick;
    int unsigned       ndig;
    longint unsigned   lo;
    longint unsigned   hi;
    logic [31:0]       magnitude;
    logic signed [31:0] value;
    for (int unsigned n = 0; n < RandomItems; n++) begin
      pick = $urandom_range(99, 0);
      if (pick < 60) begin
        ndig = $urandom_range(10, 1);
        lo   = (ndig == 1) ? 0 : 10 ** (ndig - 1);
        hi   = (10 ** ndig) - 1;
        if (hi > 64'd2147483647) begin
          hi = 64'd2147483647;
        end
        magnitude = $urandom_range(32'(hi), 32'(lo));
        value     = $urandom_range(1, 0) ? -$signed(magnitude) : $signed(magnitude);
      end else if (pick < 85) begin
        value = $urandom;
      end else begin
        value = int'($urandom_range(40, 0)) - 20;
      end
      send_number(value);
    end
  endtask

  // Receiver stall pattern; the mode is redrawn at random each time the phase counter wraps.
  always @(posedge clk_i) begin
    if (stall_phase == 96) begin
      stall_phase <= 0;
      stall_mode  <= $urandom_range(3, 0);
    end else begin
      stall_phase <= stall_phase + 1;
    end
    case (stall_mode)
      0: begin
        out_stall_i <= 1'b0;
      end
      1: begin
        out_stall_i <= ($urandom_range(9, 0) < 3);
      end
      2: begin
        out_stall_i <= (stall_phase % 4 == 1);
      end
      default: begin
        out_stall_i <= ($urandom_range(9, 0) < 7);
      end
    endcase
  end

  // Compares every character transaction with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit) begin
          $display("%0t: unexpected character %0d last %0b", $realtime, character_o,
                   last_char_o);
        end
      end else begin
        next_char = pending_chars.pop_front();
        if (character_o !== next_char.code || last_char_o !== next_char.is_last) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("%0t: expected character %0d last %0b, got %0d last %0b", $realtime,
                     next_char.code, next_char.is_last, character_o, last_char_o);
          end
        end
      end
    end
  end

  // Counts cycles in which neither channel completes a transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("FAIL signed_int_to_decimal_ascii_core");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_and_units();
    test_extremes();
    test_length_boundaries();
    test_random_numbers();
    in_valid_i <= 1'b0;
    wait (pending_chars.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("PASS signed_int_to_decimal_ascii_core");
    end else begin
      $display("FAIL signed_int_to_decimal_ascii_core");
    end
    $finish;
  end

endmodule
